// File: hdl/sdpd_pkg.sv
`timescale 1ns / 1ps
package sdpd_pkg;

    localparam int ENC_W  = 24;
    localparam int IN_W   = ((81 + 2 * ENC_W + 7) / 8) * 8;
    localparam int OUT_W  = 24;
    localparam int E2_W   = ((ENC_W + 1 > 22) ? ENC_W + 1 : 22) + 1;
    localparam int CFG_AW = 5;

    localparam int DIV_NW = 50;
    localparam int DIV_DW = 20;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam int WIN_W = 23;
    localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};

    localparam logic [12:0] FULL_TURN = 13'd5760;
    localparam logic signed [13:0] HALF_TURN_S = 14'sd2880;
    localparam logic signed [13:0] FULL_TURN_S = 14'sd5760;

    localparam logic signed [8:0] BRAKE_DRIVE = -9'sd80;

    localparam logic [2:0] REG_TOP_SPEED = 3'd0;
    localparam logic [2:0] REG_DIST_GAIN = 3'd1;
    localparam logic [2:0] REG_HEAD_P    = 3'd2;
    localparam logic [2:0] REG_HEAD_D    = 3'd3;
    localparam logic [2:0] REG_WALL_P    = 3'd4;
    localparam logic [2:0] REG_WALL_D    = 3'd5;
    localparam logic [2:0] REG_TICKS_MM  = 3'd6;

    typedef enum logic [2:0] {
        CAUSE_RUN,
        CAUSE_OVERSHOOT,
        CAUSE_REACHED,
        CAUSE_FRONT,
        CAUSE_STALL
    } t_cause;

    typedef struct packed {
        logic signed [8:0] left;
        logic signed [8:0] right;
        logic              fin;
        t_cause            cause;
    } t_result;

    // Folds an angle difference once into the closed turn around zero.
    function automatic logic signed [13:0] wrap_angle(input logic signed [13:0] a);
        logic signed [13:0] w;
        w = a;
        if (w > HALF_TURN_S) begin
            w = w - FULL_TURN_S;
        end
        if (w < -HALF_TURN_S) begin
            w = w + FULL_TURN_S;
        end
        return w;
    endfunction

    // Remainder by 180 through a slightly low reciprocal and one correction.
    function automatic logic [7:0] mod180(input logic [11:0] v);
        logic [21:0] p;
        logic [5:0]  q;
        logic [12:0] r;
        p = 22'(v) * 22'd364;
        q = p[21:16];
        r = 13'(v) - 13'(q) * 13'd180;
        if (r >= 13'd180) begin
            r = r - 13'd180;
        end
        return r[7:0];
    endfunction

endpackage

// File: hdl/sdpd_div.sv
`timescale 1ns / 1ps
module sdpd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sdpd_pkg::DIV_NW-1:0]   i_dividend,
    input  logic [sdpd_pkg::DIV_DW-1:0]   i_divisor,
    output logic                          o_done,
    output logic [sdpd_pkg::DIV_NW-1:0]   o_quot
);

    logic                        r_busy;
    logic                        r_done;
    logic [sdpd_pkg::DIV_CW-1:0] r_cnt;
    logic [sdpd_pkg::DIV_DW-1:0] r_rem;
    logic [sdpd_pkg::DIV_DW-1:0] r_dvs;
    logic [sdpd_pkg::DIV_NW-1:0] r_quo;
    logic [sdpd_pkg::DIV_DW:0]   w_shift;
    logic [sdpd_pkg::DIV_DW:0]   w_diff;
    logic                        w_ge;

    // Restoring division, one quotient bit per cycle, MSB first.
    assign w_shift = {r_rem, r_quo[sdpd_pkg::DIV_NW-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[sdpd_pkg::DIV_DW-1:0] : w_shift[sdpd_pkg::DIV_DW-1:0];
                r_quo <= {r_quo[sdpd_pkg::DIV_NW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sdpd_pkg::DIV_CW'(sdpd_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: hdl/straight_drive_pd_controller_top.sv
`timescale 1ns / 1ps
// Straight-drive PD controller. A start transaction (tuser 0) sets the goal in encoder ticks
// and snaps the heading to the nearest 45 degrees; each tick transaction (tuser 1) returns
// both motor drives, with tlast set when the move ends and the stop cause in tuser. One
// transaction is worked at a time: a start passes through the start and emit states, a tick
// while stopped goes straight to emit, a stopping tick through the tick state to emit, and a
// running tick through every state of the computation. A running tick makes two passes
// through the shared 50-step restoring divider, one for each derivative term; a single
// shared 31x21 multiplier does the goal, gain and time-scale products in turn. A result that
// waits on m_axis_tready holds the next transaction in the emit state. Configuration
// registers sit on the APB port at byte address 4 times their index.
module straight_drive_pd_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: distance_mm, heading, left_count, right_count, left_range, right_range,
    // front_range, elapsed_us, zero fill.
    input  logic [sdpd_pkg::IN_W-1:0]     s_axis_tdata,
    // tuser: mode.
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: left_drive, right_drive, zero fill.
    output logic [sdpd_pkg::OUT_W-1:0]    m_axis_tdata,
    // tuser: stop_cause.
    output logic [2:0]                    m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdpd_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int EW = sdpd_pkg::ENC_W;
    localparam int E2 = sdpd_pkg::E2_W;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_TICK, S_BASE, S_WP, S_WD, S_WD6, S_WDIV0, S_WDIV, S_CORR,
        S_HP, S_HD, S_HD6, S_HDIV0, S_HDIV, S_STEER, S_EMIT
    } t_state;

    t_state r_state;

    logic [7:0]  r_top_speed;
    logic [15:0] r_dist_gain, r_head_p, r_head_d, r_wall_p, r_wall_d, r_ticks_mm;

    logic [11:0]           r_dist;
    logic [12:0]           r_head;
    logic signed [EW-1:0]  r_lc, r_rc;
    logic [11:0]           r_lr, r_rr, r_fr;
    logic [19:0]           r_el;

    logic [19:0]                  r_goal;
    logic [12:0]                  r_goal_head;
    logic signed [13:0]           r_prev_head;
    logic signed [8:0]            r_prev_wall;
    logic [sdpd_pkg::WIN_W-1:0]   r_win;
    logic signed [EW-1:0]         r_lref, r_rref;
    logic                         r_moving;

    logic signed [E2-1:0] r_e2;
    logic [19:0]          r_dt;
    logic signed [8:0]    r_off;
    logic [16:0]          r_base;
    logic signed [51:0]   r_prod;
    logic signed [41:0]   r_term;
    logic signed [41:0]   r_acc;
    logic                 r_neg;
    logic signed [13:0]   r_err;

    sdpd_pkg::t_result r_res;
    sdpd_pkg::t_result r_out;
    logic              r_ovalid;

    logic                 w_accept;
    logic [12:0]          w_head_in;
    logic signed [30:0]   w_mul_a;
    logic signed [20:0]   w_mul_b;
    logic signed [51:0]   w_prod;
    logic                 w_div_start;
    logic [51:0]          w_div_mag;
    logic                 w_div_done;
    logic [sdpd_pkg::DIV_NW-1:0] w_quot;
    logic signed [41:0]   w_quot_s;

    logic [3:0]           w_q;
    logic                 w_tie;
    logic [2:0]           w_k;
    logic [12:0]          w_snap;
    logic signed [13:0]   w_err0;

    logic [sdpd_pkg::WIN_W:0]   w_win_sum;
    logic [sdpd_pkg::WIN_W-1:0] w_win;
    logic signed [EW:0]   w_sum, w_dl, w_dr;
    logic signed [E2-1:0] w_e2;
    logic                 w_over, w_reach, w_front, w_expire, w_still;
    logic [7:0]           w_l180, w_r180;
    logic [8:0]           w_half;
    logic signed [8:0]    w_off;

    logic [25:0]          w_bprod;
    logic [16:0]          w_top256;
    logic [16:0]          w_base;
    logic signed [12:0]   w_cclamp;
    logic signed [12:0]   w_corr;
    logic signed [13:0]   w_err;
    logic signed [41:0]   w_sdiv;
    logic signed [15:0]   w_steer;
    logic signed [18:0]   w_lsum, w_rsum;
    logic [7:0]           w_ldrv, w_rdrv;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Configuration port.
    assign pready = 1'b1;
    always_comb begin
        case (paddr[4:2])
            sdpd_pkg::REG_TOP_SPEED: prdata = {24'd0, r_top_speed};
            sdpd_pkg::REG_DIST_GAIN: prdata = {16'd0, r_dist_gain};
            sdpd_pkg::REG_HEAD_P:    prdata = {16'd0, r_head_p};
            sdpd_pkg::REG_HEAD_D:    prdata = {16'd0, r_head_d};
            sdpd_pkg::REG_WALL_P:    prdata = {16'd0, r_wall_p};
            sdpd_pkg::REG_WALL_D:    prdata = {16'd0, r_wall_d};
            sdpd_pkg::REG_TICKS_MM:  prdata = {16'd0, r_ticks_mm};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_speed <= 8'd100;
            r_dist_gain <= 16'd1536;
            r_head_p    <= 16'd1050;
            r_head_d    <= 16'd102;
            r_wall_p    <= 16'd512;
            r_wall_d    <= 16'd102;
            r_ticks_mm  <= 16'd4096;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                sdpd_pkg::REG_TOP_SPEED: r_top_speed <= pwdata[7:0];
                sdpd_pkg::REG_DIST_GAIN: r_dist_gain <= pwdata[15:0];
                sdpd_pkg::REG_HEAD_P:    r_head_p    <= pwdata[15:0];
                sdpd_pkg::REG_HEAD_D:    r_head_d    <= pwdata[15:0];
                sdpd_pkg::REG_WALL_P:    r_wall_p    <= pwdata[15:0];
                sdpd_pkg::REG_WALL_D:    r_wall_d    <= pwdata[15:0];
                sdpd_pkg::REG_TICKS_MM:  r_ticks_mm  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign w_head_in = (s_axis_tdata[24:12] >= sdpd_pkg::FULL_TURN)
                     ? s_axis_tdata[24:12] - sdpd_pkg::FULL_TURN : s_axis_tdata[24:12];

    // Heading snap: count the half-way points passed; on an exact tie the lower
    // multiple wins, and the tie between the last multiple and zero goes to zero.
    always_comb begin
        w_q   = 4'd0;
        w_tie = 1'b0;
        for (int j = 1; j <= 8; j++) begin
            if (r_head >= 13'(720 * j - 360)) begin
                w_q = w_q + 4'd1;
            end
            if (r_head == 13'(720 * j - 360)) begin
                w_tie = 1'b1;
            end
        end
        if (w_tie && w_q != 4'd8) begin
            w_k = 3'(w_q - 4'd1);
        end else begin
            w_k = w_q[2:0];
        end
        w_snap = 13'(w_k) * 13'd720;
        w_err0 = sdpd_pkg::wrap_angle(signed'({1'b0, w_snap}) - signed'({1'b0, r_head}));
    end

    // Stop checks and wall offset.
    assign w_win_sum = {1'b0, r_win} + (sdpd_pkg::WIN_W + 1)'(r_el);
    assign w_win     = w_win_sum[sdpd_pkg::WIN_W] ? sdpd_pkg::WIN_MAX
                                                   : w_win_sum[sdpd_pkg::WIN_W-1:0];
    assign w_sum     = (EW + 1)'(r_rc) - (EW + 1)'(r_lc);
    assign w_e2      = E2'({r_goal, 1'b0}) - E2'(w_sum);
    assign w_over    = w_e2 <= E2'(0);
    assign w_reach   = w_e2 < E2'(10);
    assign w_front   = (r_fr != 12'd0) && (r_fr < 12'd20) && (w_win > 23'd100000);
    assign w_expire  = w_win > 23'd5000000;
    assign w_dl      = (EW + 1)'(r_lc) - (EW + 1)'(r_lref);
    assign w_dr      = (EW + 1)'(r_rc) - (EW + 1)'(r_rref);
    assign w_still   = (w_dl > -(EW + 1)'(20)) && (w_dl < (EW + 1)'(20))
                    && (w_dr > -(EW + 1)'(20)) && (w_dr < (EW + 1)'(20));
    assign w_l180    = sdpd_pkg::mod180(r_lr);
    assign w_r180    = sdpd_pkg::mod180(r_rr);
    assign w_half    = ({1'b0, w_l180} + {1'b0, w_r180}) >> 1;
    assign w_off     = ((r_lr != 12'd0) && (r_rr != 12'd0))
                     ? signed'({1'b0, w_l180}) - signed'(w_half) : 9'sd0;

    // Shared multiplier; the product is registered before use, but for the goal product taken directly in S_START.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_START: begin
                w_mul_a = signed'(31'(r_dist));
                w_mul_b = signed'(21'(r_ticks_mm));
            end
            S_BASE: begin
                w_mul_a = signed'(31'(r_e2[10:0]));
                w_mul_b = signed'(21'(r_dist_gain));
            end
            S_WP: begin
                w_mul_a = 31'(r_off);
                w_mul_b = signed'(21'(r_wall_p));
            end
            S_WD: begin
                w_mul_a = 31'(10'(r_off) - 10'(r_prev_wall));
                w_mul_b = signed'(21'(r_wall_d));
            end
            S_HP: begin
                w_mul_a = 31'(r_err);
                w_mul_b = signed'(21'(r_head_p));
            end
            S_HD: begin
                w_mul_a = 31'(15'(r_err) - 15'(r_prev_head));
                w_mul_b = signed'(21'(r_head_d));
            end
            S_WD6, S_HD6: begin
                w_mul_a = r_prod[30:0];
                w_mul_b = 21'sd1000000;
            end
            default: ;
        endcase
    end
    assign w_prod = 52'(w_mul_a) * 52'(w_mul_b);

    assign w_div_start = (r_state == S_WDIV0) || (r_state == S_HDIV0);
    assign w_div_mag   = r_prod[51] ? -r_prod : r_prod;

    sdpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_mag[sdpd_pkg::DIV_NW-1:0]),
        .i_divisor  (r_dt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_quot_s = r_neg ? -signed'({1'b0, w_quot[40:0]}) : signed'({1'b0, w_quot[40:0]});

    // Base speed from the distance error.
    assign w_bprod  = r_prod[26:1];
    assign w_top256 = {1'b0, r_top_speed, 8'd0};
    always_comb begin
        if (r_e2 > E2'(800)) begin
            w_base = w_top256;
        end else if (r_e2 > E2'(100)) begin
            if (w_bprod < 26'd10240) begin
                w_base = 17'd10240;
            end else if (w_bprod > 26'(w_top256)) begin
                w_base = w_top256;
            end else begin
                w_base = w_bprod[16:0];
            end
        end else begin
            w_base = 17'd0;
        end
    end

    // Wall correction and heading error.
    always_comb begin
        if (r_acc > 42'sd2048) begin
            w_cclamp = 13'sd2048;
        end else if (r_acc < -42'sd2048) begin
            w_cclamp = -13'sd2048;
        end else begin
            w_cclamp = r_acc[12:0];
        end
        w_corr = w_cclamp / 13'sd16;
        w_err  = sdpd_pkg::wrap_angle(signed'({1'b0, r_goal_head}) + 14'(w_corr)
                                      - signed'({1'b0, r_head}));
    end

    // Steering and drive levels.
    always_comb begin
        w_sdiv = r_acc / 42'sd16;
        if (w_sdiv > 42'sd15360) begin
            w_steer = 16'sd15360;
        end else if (w_sdiv < -42'sd15360) begin
            w_steer = -16'sd15360;
        end else begin
            w_steer = w_sdiv[15:0];
        end
        w_lsum = signed'(19'(r_base)) - 19'(w_steer);
        w_rsum = signed'(19'(r_base)) + 19'(w_steer);
        if (w_lsum < 19'sd0) begin
            w_ldrv = 8'd0;
        end else if (w_lsum > 19'sd65280) begin
            w_ldrv = 8'd255;
        end else begin
            w_ldrv = w_lsum[15:8];
        end
        if (w_rsum < 19'sd0) begin
            w_rdrv = 8'd0;
        end else if (w_rsum > 19'sd65280) begin
            w_rdrv = 8'd255;
        end else begin
            w_rdrv = w_rsum[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_moving    <= 1'b0;
            r_goal      <= '0;
            r_goal_head <= '0;
            r_prev_head <= '0;
            r_prev_wall <= '0;
            r_win       <= '0;
            r_lref      <= '0;
            r_rref      <= '0;
        end else begin
            r_prod <= w_prod;
            if (r_state == S_EMIT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_dist <= s_axis_tdata[11:0];
                        r_head <= w_head_in;
                        r_lc   <= s_axis_tdata[25 +: EW];
                        r_rc   <= s_axis_tdata[25 + EW +: EW];
                        r_lr   <= s_axis_tdata[25 + 2 * EW +: 12];
                        r_rr   <= s_axis_tdata[37 + 2 * EW +: 12];
                        r_fr   <= s_axis_tdata[49 + 2 * EW +: 12];
                        r_el   <= s_axis_tdata[61 + 2 * EW +: 20];
                        r_res  <= '{left: 9'sd0, right: 9'sd0, fin: 1'b0,
                                    cause: sdpd_pkg::CAUSE_RUN};
                        if (!s_axis_tuser) begin
                            r_state <= S_START;
                        end else if (r_moving) begin
                            r_state <= S_TICK;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_START: begin
                    r_goal      <= w_prod[27:8];
                    r_goal_head <= w_snap;
                    r_prev_head <= w_err0;
                    r_win       <= '0;
                    r_lref      <= '0;
                    r_rref      <= '0;
                    r_moving    <= 1'b1;
                    r_state     <= S_EMIT;
                end
                S_TICK: begin
                    r_e2  <= w_e2;
                    r_dt  <= (r_el < 20'd1000) ? 20'd1000 : r_el;
                    r_off <= w_off;
                    if (w_over || w_reach) begin
                        r_win    <= w_win;
                        r_moving <= 1'b0;
                        r_res    <= '{left: sdpd_pkg::BRAKE_DRIVE, right: sdpd_pkg::BRAKE_DRIVE,
                                      fin: 1'b1, cause: w_over ? sdpd_pkg::CAUSE_OVERSHOOT
                                                              : sdpd_pkg::CAUSE_REACHED};
                        r_state  <= S_EMIT;
                    end else if (w_front || (w_expire && w_still)) begin
                        r_win    <= w_win;
                        r_moving <= 1'b0;
                        r_res    <= '{left: 9'sd0, right: 9'sd0, fin: 1'b1,
                                      cause: w_front ? sdpd_pkg::CAUSE_FRONT
                                                     : sdpd_pkg::CAUSE_STALL};
                        r_state  <= S_EMIT;
                    end else begin
                        if (w_expire) begin
                            r_win  <= '0;
                            r_lref <= r_lc;
                            r_rref <= r_rc;
                        end else begin
                            r_win  <= w_win;
                        end
                        r_state <= S_BASE;
                    end
                end
                S_BASE: r_state <= S_WP;
                S_WP: begin
                    r_base  <= w_base;
                    r_state <= S_WD;
                end
                S_WD: begin
                    r_term  <= r_prod[41:0];
                    r_state <= S_WD6;
                end
                S_WD6: r_state <= S_WDIV0;
                S_WDIV0: begin
                    r_neg   <= r_prod[51];
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    if (w_div_done) begin
                        r_acc   <= r_term + w_quot_s;
                        r_state <= S_CORR;
                    end
                end
                S_CORR: begin
                    r_err       <= w_err;
                    r_prev_wall <= r_off;
                    r_state     <= S_HP;
                end
                S_HP: r_state <= S_HD;
                S_HD: begin
                    r_term  <= r_prod[41:0];
                    r_state <= S_HD6;
                end
                S_HD6: r_state <= S_HDIV0;
                S_HDIV0: begin
                    r_neg   <= r_prod[51];
                    r_state <= S_HDIV;
                end
                S_HDIV: begin
                    if (w_div_done) begin
                        r_acc   <= r_term + w_quot_s;
                        r_state <= S_STEER;
                    end
                end
                S_STEER: begin
                    r_prev_head <= r_err;
                    r_res       <= '{left: signed'({1'b0, w_ldrv}), right: signed'({1'b0, w_rdrv}),
                                     fin: 1'b0, cause: sdpd_pkg::CAUSE_RUN};
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_out    <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_out.right, r_out.left};
    assign m_axis_tuser  = r_out.cause;
    assign m_axis_tlast  = r_out.fin;

endmodule

// File: tb/straight_drive_pd_controller_top_tb.sv
`timescale 1ns / 1ps
module straight_drive_pd_controller_top_tb;

    typedef struct {
        logic              mode;
        logic [11:0]       dist_mm;
        logic [12:0]       heading;
        logic signed [23:0] left_cnt;
        logic signed [23:0] right_cnt;
        logic [11:0]       left_rng;
        logic [11:0]       right_rng;
        logic [11:0]       front_rng;
        logic [19:0]       elapsed;
    } t_motion;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [sdpd_pkg::IN_W-1:0]   s_axis_tdata;
    logic                        s_axis_tuser;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [sdpd_pkg::OUT_W-1:0]  m_axis_tdata;
    logic [2:0]                  m_axis_tuser;
    logic                        m_axis_tlast;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [sdpd_pkg::CFG_AW-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    straight_drive_pd_controller_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Controller settings as the block should hold them.
    longint cfg_top_speed = 100;
    longint cfg_dist_gain = 1536;
    longint cfg_head_p    = 1050;
    longint cfg_head_d    = 102;
    longint cfg_wall_p    = 512;
    longint cfg_wall_d    = 102;
    longint cfg_ticks_mm  = 4096;

    // Predicted controller state.
    longint goal_ticks;
    longint goal_head;
    longint prev_head_err;
    longint prev_wall_off;
    longint win_us;
    longint win_left_ref;
    longint win_right_ref;
    bit     is_moving;

    t_motion           pending_motion[$];
    sdpd_pkg::t_result expected_drive[$];
    int                error_count;
    int                hold_requests;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint clamp_l(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic longint fold_angle(longint a);
        if (a > 2880) a -= 5760;
        if (a < -2880) a += 5760;
        return a;
    endfunction

    function automatic longint abs_l(longint a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic sdpd_pkg::t_result drive_outcome(longint l, longint r, bit fin,
                                                        sdpd_pkg::t_cause cause);
        sdpd_pkg::t_result res;
        res.left  = l[8:0];
        res.right = r[8:0];
        res.fin   = fin;
        res.cause = cause;
        return res;
    endfunction

    function automatic sdpd_pkg::t_result predict_drive(t_motion it);
        longint head, lc, rc, dt, sum, e2, base, off, corr, err, steer, lm, rm;
        longint best_d, d;
        int     best;
        head = it.heading;
        lc   = it.left_cnt;
        rc   = it.right_cnt;
        if (head >= 5760) head -= 5760;
        if (it.mode == 1'b0) begin
            goal_ticks = (longint'(it.dist_mm) * cfg_ticks_mm) >>> 8;
            best   = 0;
            best_d = 0;
            for (int i = 0; i < 8; i++) begin
                d = fold_angle(i * 720 - head);
                if (i == 0 || abs_l(d) < abs_l(best_d)) begin
                    best   = i;
                    best_d = d;
                end
            end
            goal_head     = best * 720;
            prev_head_err = fold_angle(goal_head - head);
            win_us        = 0;
            win_left_ref  = 0;
            win_right_ref = 0;
            is_moving     = 1'b1;
            return drive_outcome(0, 0, 1'b0, sdpd_pkg::CAUSE_RUN);
        end
        if (!is_moving) return drive_outcome(0, 0, 1'b0, sdpd_pkg::CAUSE_RUN);

        win_us += it.elapsed;
        if (win_us > 8388607) win_us = 8388607;
        dt  = (it.elapsed < 1000) ? 1000 : it.elapsed;
        sum = rc - lc;
        e2  = 2 * goal_ticks - sum;
        if (sum >= 2 * goal_ticks) begin
            is_moving = 1'b0;
            return drive_outcome(-80, -80, 1'b1, sdpd_pkg::CAUSE_OVERSHOOT);
        end
        if (e2 < 10) begin
            is_moving = 1'b0;
            return drive_outcome(-80, -80, 1'b1, sdpd_pkg::CAUSE_REACHED);
        end
        if (it.front_rng > 0 && it.front_rng < 20 && win_us > 100000) begin
            is_moving = 1'b0;
            return drive_outcome(0, 0, 1'b1, sdpd_pkg::CAUSE_FRONT);
        end
        if (win_us > 5000000) begin
            if (abs_l(lc - win_left_ref) < 20 && abs_l(rc - win_right_ref) < 20) begin
                is_moving = 1'b0;
                return drive_outcome(0, 0, 1'b1, sdpd_pkg::CAUSE_STALL);
            end
            win_us        = 0;
            win_left_ref  = lc;
            win_right_ref = rc;
        end

        if (e2 > 800) begin
            base = cfg_top_speed * 256;
        end else if (e2 > 100) begin
            base = (cfg_dist_gain * e2) / 2;
            if (base < 40 * 256) base = 40 * 256;
            else if (base > cfg_top_speed * 256) base = cfg_top_speed * 256;
        end else begin
            base = 0;
        end

        off = 0;
        if (it.left_rng > 0 && it.right_rng > 0) begin
            lm  = longint'(it.left_rng) % 180;
            rm  = longint'(it.right_rng) % 180;
            off = lm - (lm + rm) / 2;
        end
        corr = cfg_wall_p * off + (cfg_wall_d * (off - prev_wall_off) * 1000000) / dt;
        corr = clamp_l(corr, -2048, 2048) / 16;
        prev_wall_off = off;

        err   = fold_angle(goal_head + corr - head);
        steer = (cfg_head_p * err + (cfg_head_d * (err - prev_head_err) * 1000000) / dt) / 16;
        steer = clamp_l(steer, -15360, 15360);
        prev_head_err = err;
        return drive_outcome(clamp_l(base - steer, 0, 65280) / 256,
                             clamp_l(base + steer, 0, 65280) / 256, 1'b0, sdpd_pkg::CAUSE_RUN);
    endfunction

    // Source side: bursts of random length separated by random gaps.
    logic in_fire;
    int   burst_left;
    int   gap_left;
    t_motion cur;

    always @(posedge i_clk) begin
        in_fire <= s_axis_tvalid && s_axis_tready;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else if (s_axis_tvalid && !in_fire) begin
            s_axis_tvalid <= 1'b1;
        end else if (gap_left > 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= gap_left - 1;
        end else if (pending_motion.size() > 0) begin
            cur = pending_motion.pop_front();
            s_axis_tdata  <= {7'd0, cur.elapsed, cur.front_rng, cur.right_rng, cur.left_rng,
                              cur.right_cnt, cur.left_cnt, cur.heading, cur.dist_mm};
            s_axis_tuser  <= cur.mode;
            s_axis_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 150);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Sink side: changing stall pattern, plus long hold-offs on request.
    int hold_left;
    int holds_done;
    int stall_style;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            holds_done    <= 0;
            stall_style   <= 0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 2000;
            holds_done    <= holds_done + 1;
        end else begin
            if ($urandom_range(0, 300) == 0) stall_style <= $urandom_range(0, 2);
            case (stall_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Checks each result, then records the prediction for an accepted transaction.
    sdpd_pkg::t_result want;
    t_motion           got_in;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_drive.size() == 0) begin
                $display("%0t: unexpected result data=%h cause=%0d last=%b", $time,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end else begin
                want = expected_drive.pop_front();
                if (m_axis_tdata[8:0] !== want.left) begin
                    $display("%0t: left drive expected %0d got %0d", $time,
                             want.left, $signed(m_axis_tdata[8:0]));
                    error_count++;
                end
                if (m_axis_tdata[17:9] !== want.right) begin
                    $display("%0t: right drive expected %0d got %0d", $time,
                             want.right, $signed(m_axis_tdata[17:9]));
                    error_count++;
                end
                if (m_axis_tlast !== want.fin) begin
                    $display("%0t: finished expected %b got %b", $time, want.fin, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser !== want.cause) begin
                    $display("%0t: stop cause expected %0d got %0d", $time,
                             want.cause, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[23:18] !== 6'd0) begin
                    $display("%0t: fill bits expected 0 got %h", $time, m_axis_tdata[23:18]);
                    error_count++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            got_in.mode      = s_axis_tuser;
            got_in.dist_mm   = s_axis_tdata[11:0];
            got_in.heading   = s_axis_tdata[24:12];
            got_in.left_cnt  = s_axis_tdata[48:25];
            got_in.right_cnt = s_axis_tdata[72:49];
            got_in.left_rng  = s_axis_tdata[84:73];
            got_in.right_rng = s_axis_tdata[96:85];
            got_in.front_rng = s_axis_tdata[108:97];
            got_in.elapsed   = s_axis_tdata[128:109];
            expected_drive.push_back(predict_drive(got_in));
        end
    end

    task automatic queue_motion(logic mode, logic [11:0] move_mm, logic [12:0] head,
                                logic signed [23:0] lc, logic signed [23:0] rc,
                                logic [11:0] lr, logic [11:0] rr, logic [11:0] fr,
                                logic [19:0] el);
        t_motion it;
        it.mode = mode;   it.dist_mm = move_mm; it.heading = head;
        it.left_cnt = lc; it.right_cnt = rc;  it.left_rng = lr;
        it.right_rng = rr; it.front_rng = fr; it.elapsed = el;
        pending_motion.push_back(it);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sdpd_pkg::CFG_AW'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            sdpd_pkg::REG_TOP_SPEED: cfg_top_speed = value[7:0];
            sdpd_pkg::REG_DIST_GAIN: cfg_dist_gain = value[15:0];
            sdpd_pkg::REG_HEAD_P:    cfg_head_p    = value[15:0];
            sdpd_pkg::REG_HEAD_D:    cfg_head_d    = value[15:0];
            sdpd_pkg::REG_WALL_P:    cfg_wall_p    = value[15:0];
            sdpd_pkg::REG_WALL_D:    cfg_wall_d    = value[15:0];
            default:                 cfg_ticks_mm  = value[15:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (pending_motion.size() > 0 || s_axis_tvalid || expected_drive.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [19:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0: return 20'($urandom_range(0, 999));
            1: return 20'($urandom());
            2: return 20'($urandom_range(200000, 1000000));
            default: return 20'($urandom_range(1000, 30000));
        endcase
    endfunction

    // One plausible move: a start, then ticks with the wheels advancing toward the goal.
    task automatic queue_move();
        longint goal, lc, rc, step;
        int     kind, n;
        logic [12:0] head;
        logic [11:0] move_mm;
        kind = $urandom_range(0, 9);
        move_mm = ($urandom_range(0, 7) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 300));
        head = ($urandom_range(0, 5) == 0) ? 13'($urandom()) : 13'($urandom_range(0, 5759));
        goal = (longint'(move_mm) * cfg_ticks_mm) >>> 8;
        lc   = 0;
        rc   = 0;
        n    = $urandom_range(3, 25);
        queue_motion(1'b0, move_mm, head, 24'($urandom()), 24'($urandom()), 12'($urandom()),
                     12'($urandom()), 12'($urandom()), 20'($urandom()));
        for (int k = 0; k < n; k++) begin
            step = (kind == 0) ? $urandom_range(0, 9) : (2 * goal) / n + $urandom_range(0, 40);
            lc  -= step / 2 + $urandom_range(0, 3);
            rc  += step / 2 + $urandom_range(0, 3);
            head = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 5759))
                                               : 13'(head + $urandom_range(0, 64) - 32);
            queue_motion(1'b1, 12'($urandom()), head, 24'(lc), 24'(rc),
                         ($urandom_range(0, 4) == 0) ? 12'd0 : 12'($urandom_range(1, 400)),
                         ($urandom_range(0, 4) == 0) ? 12'd0 : 12'($urandom_range(1, 400)),
                         (kind == 1) ? 12'($urandom_range(0, 25)) : 12'($urandom()),
                         (kind == 0) ? 20'($urandom_range(300000, 1048575)) : pick_elapsed());
        end
    endtask

    task automatic queue_noise();
        queue_motion(1'($urandom()), 12'($urandom()), 13'($urandom()), 24'($urandom()),
                     24'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                     20'($urandom()));
    endtask

    task automatic random_phase(int count);
        int base;
        base = pending_motion.size();
        while (pending_motion.size() - base < count) begin
            if ($urandom_range(0, 7) == 0) queue_noise();
            else queue_move();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        in_fire       = 1'b0;
        error_count   = 0;
        hold_requests = 0;
        goal_ticks = 0; goal_head = 0; prev_head_err = 0; prev_wall_off = 0;
        win_us = 0; win_left_ref = 0; win_right_ref = 0; is_moving = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: idle tick, zero goal, tie snaps, folded heading, overshoot and stall stops.
        queue_motion(1'b1, 12'd4095, 13'd100, 24'sd5, 24'sd9, 12'd100, 12'd50, 12'd10, 20'd5000);
        queue_motion(1'b0, 12'd0, 13'd360, 0, 0, 0, 0, 0, 0);
        queue_motion(1'b1, 0, 13'd360, 0, 0, 0, 0, 0, 20'd0);
        queue_motion(1'b0, 12'd100, 13'd5400, 0, 0, 0, 0, 0, 0);
        queue_motion(1'b1, 0, 13'd5390, -24'sd100, 24'sd100, 12'd179, 12'd4095, 12'd0, 20'd0);
        queue_motion(1'b1, 0, 13'd8191, -24'sd300, 24'sd300, 12'd180, 12'd1, 12'd4095,
                     20'hFFFFF);
        queue_motion(1'b1, 0, 13'd20, -24'sd795, 24'sd796, 12'd90, 12'd90, 12'd0, 20'd999);
        queue_motion(1'b0, 12'd4095, 13'd6000, 0, 0, 0, 0, 0, 0);
        queue_motion(1'b1, 0, 13'd240, 24'sh800000, 24'sh7FFFFF, 12'd4095, 12'd4095, 12'd10,
                     20'd150000);
        queue_motion(1'b0, 12'd50, 13'd1000, 0, 0, 0, 0, 0, 0);
        for (int k = 0; k < 6; k++)
            queue_motion(1'b1, 0, 13'd1000, -24'sd3, 24'sd3, 12'd200, 12'd10, 12'd0,
                         20'd1000000);
        queue_motion(1'b0, 12'd10, 13'd700, 0, 0, 0, 0, 0, 0);
        queue_motion(1'b1, 0, 13'd700, -24'sd80, 24'sd80, 12'd300, 12'd60, 12'd0, 20'd2000);
        queue_motion(1'b1, 0, 13'd700, -24'sd100, 24'sd100, 0, 0, 0, 20'd2000);
        drain();

        random_phase(230);
        hold_requests = 1;
        drain();

        write_reg(sdpd_pkg::REG_TOP_SPEED, 32'd255);
        write_reg(sdpd_pkg::REG_DIST_GAIN, 32'd65535);
        write_reg(sdpd_pkg::REG_HEAD_P, 32'd65535);
        write_reg(sdpd_pkg::REG_HEAD_D, 32'd65535);
        write_reg(sdpd_pkg::REG_WALL_P, 32'd65535);
        write_reg(sdpd_pkg::REG_WALL_D, 32'd65535);
        write_reg(sdpd_pkg::REG_TICKS_MM, 32'd65535);
        random_phase(230);
        drain();

        write_reg(sdpd_pkg::REG_TOP_SPEED, 32'd0);
        write_reg(sdpd_pkg::REG_DIST_GAIN, 32'd0);
        write_reg(sdpd_pkg::REG_HEAD_P, 32'd0);
        write_reg(sdpd_pkg::REG_HEAD_D, 32'd0);
        write_reg(sdpd_pkg::REG_WALL_P, 32'd0);
        write_reg(sdpd_pkg::REG_WALL_D, 32'd0);
        write_reg(sdpd_pkg::REG_TICKS_MM, 32'd0);
        random_phase(120);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_reg(sdpd_pkg::REG_TOP_SPEED, $urandom());
            write_reg(sdpd_pkg::REG_DIST_GAIN, $urandom_range(0, 4000));
            write_reg(sdpd_pkg::REG_HEAD_P, $urandom_range(0, 3000));
            write_reg(sdpd_pkg::REG_HEAD_D, $urandom_range(0, 600));
            write_reg(sdpd_pkg::REG_WALL_P, $urandom_range(0, 2000));
            write_reg(sdpd_pkg::REG_WALL_D, $urandom());
            write_reg(sdpd_pkg::REG_TICKS_MM, $urandom_range(256, 8192));
            random_phase(210);
            if (p == 1) hold_requests = 2;
            drain();
        end

        if (error_count == 0 && expected_drive.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
